### src/latching_valve_pulse_sequencer_core_assert.svh
// Assertion macros for the checker file of the valve pulse sequencer.
`ifndef LATCHING_VALVE_PULSE_SEQUENCER_CORE_ASSERT_SVH
`define LATCHING_VALVE_PULSE_SEQUENCER_CORE_ASSERT_SVH

// checked only while out of reset
`define LVPS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LVPS_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/lvps_pkg.sv
// Shared types and codes for the latching valve pulse sequencer.
package lvps_pkg;

    // word kinds carried in tuser
    localparam logic [1:0] MODE_ORDER = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_SET   = 2'd2;

    // sequence phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRE  = 2'd1;
    localparam logic [1:0] PH_MAIN = 2'd2;

    // valve positions
    localparam logic [1:0] POS_CLOSED  = 2'd0;
    localparam logic [1:0] POS_OPEN    = 2'd1;
    localparam logic [1:0] POS_UNKNOWN = 2'd2;

    // set-state codes
    localparam logic [7:0] CODE_CLOSED  = 8'h00;
    localparam logic [7:0] CODE_OPEN    = 8'h01;
    localparam logic [7:0] CODE_UNKNOWN = 8'hFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_V0_CLOSED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_V0_OPEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_V1_CLOSED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_V1_OPEN   = 3'd4;

    localparam int NUM_VALVES = 2;
    localparam int DRIVE_W    = 4;

    typedef struct packed {
        logic       fire;   // word processed this cycle
        logic [1:0] mode;
        logic       sel;    // word addresses this valve
        logic       open;
        logic [7:0] code;
    } t_valve_cmd;

    typedef struct packed {
        logic [1:0] pos;
        logic       busy;
        logic       pending;
    } t_valve_status;

endpackage

### src/lvps_valve.sv
// One valve: pending order, sequence phase, pulse timer and next-state logic.
module lvps_valve #(
    parameter int NUM_RELAYS = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lvps_pkg::t_valve_cmd          i_cmd,
    input  logic [7:0]                    i_map_closed,
    input  logic [7:0]                    i_map_open,
    input  logic [TIMER_BITS-1:0]         i_pulse_load,
    output lvps_pkg::t_valve_status       o_status,
    output logic [$clog2(NUM_RELAYS)-1:0] o_relay
);

    localparam int RW = $clog2(NUM_RELAYS);
    localparam logic [7:0] NR8 = 8'(NUM_RELAYS);
    localparam logic [TIMER_BITS-1:0] T1 = TIMER_BITS'(1);

    logic [1:0]            r_pos, n_pos;
    logic                  r_wait, n_wait;
    logic                  r_otgt, n_otgt;
    logic [1:0]            r_phase, n_phase;
    logic                  r_rtgt, n_rtgt;
    logic [RW-1:0]         r_relay, n_relay;
    logic [TIMER_BITS-1:0] r_timer, n_timer;

    logic [7:0] w_map_adv;
    assign w_map_adv = r_rtgt ? i_map_open : i_map_closed;

    always_comb begin
        logic       unk;
        logic [7:0] m_sel;
        unk     = 1'b0;
        m_sel   = 8'd0;
        n_pos   = r_pos;
        n_wait  = r_wait;
        n_otgt  = r_otgt;
        n_phase = r_phase;
        n_rtgt  = r_rtgt;
        n_relay = r_relay;
        n_timer = r_timer;
        if (i_cmd.fire) begin
            case (i_cmd.mode)
                lvps_pkg::MODE_ORDER: begin
                    if (i_cmd.sel) begin
                        n_wait = 1'b1;
                        n_otgt = i_cmd.open;
                    end
                end
                lvps_pkg::MODE_TICK: begin
                    // timers advance first
                    if (r_phase != lvps_pkg::PH_IDLE) begin
                        if (r_timer > T1) begin
                            n_timer = r_timer - T1;
                        end else begin
                            n_timer = '0;
                            if (r_phase == lvps_pkg::PH_PRE) begin
                                if (w_map_adv < NR8) begin
                                    n_relay = w_map_adv[RW-1:0];
                                    n_timer = i_pulse_load;
                                    n_phase = lvps_pkg::PH_MAIN;
                                end else begin
                                    n_pos   = lvps_pkg::POS_UNKNOWN;
                                    n_phase = lvps_pkg::PH_IDLE;
                                end
                            end else begin
                                n_pos   = {1'b0, r_rtgt};
                                n_phase = lvps_pkg::PH_IDLE;
                            end
                        end
                    end
                    // then an idle valve takes its pending order
                    if (n_phase == lvps_pkg::PH_IDLE && r_wait) begin
                        n_wait = 1'b0;
                        n_rtgt = r_otgt;
                        if (n_pos != {1'b0, r_otgt}) begin
                            unk   = (n_pos == lvps_pkg::POS_UNKNOWN);
                            // unknown: pulse the opposite position first
                            m_sel = (r_otgt ^ unk) ? i_map_open : i_map_closed;
                            if (m_sel < NR8) begin
                                n_relay = m_sel[RW-1:0];
                                n_timer = i_pulse_load;
                                n_phase = unk ? lvps_pkg::PH_PRE : lvps_pkg::PH_MAIN;
                            end else begin
                                n_pos   = lvps_pkg::POS_UNKNOWN;
                                n_phase = lvps_pkg::PH_IDLE;
                            end
                        end
                    end
                end
                lvps_pkg::MODE_SET: begin
                    if (i_cmd.sel) begin
                        if (i_cmd.code == lvps_pkg::CODE_CLOSED) begin
                            n_pos = lvps_pkg::POS_CLOSED;
                        end else if (i_cmd.code == lvps_pkg::CODE_OPEN) begin
                            n_pos = lvps_pkg::POS_OPEN;
                        end else if (i_cmd.code == lvps_pkg::CODE_UNKNOWN) begin
                            n_pos = lvps_pkg::POS_UNKNOWN;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= lvps_pkg::POS_UNKNOWN;
            r_wait  <= 1'b0;
            r_otgt  <= 1'b0;
            r_phase <= lvps_pkg::PH_IDLE;
            r_rtgt  <= 1'b0;
            r_relay <= '0;
            r_timer <= '0;
        end else begin
            r_pos   <= n_pos;
            r_wait  <= n_wait;
            r_otgt  <= n_otgt;
            r_phase <= n_phase;
            r_rtgt  <= n_rtgt;
            r_relay <= n_relay;
            r_timer <= n_timer;
        end
    end

    // status after this word, for the result register
    assign o_status.pos     = n_pos;
    assign o_status.busy    = (n_phase != lvps_pkg::PH_IDLE);
    assign o_status.pending = n_wait;
    assign o_relay          = n_relay;

endmodule

### src/latching_valve_pulse_sequencer_core.sv
// Top level of the latching valve pulse sequencer: stream ports, config and result register.
//
// Drives two latching valves through a bank of pulse relays.
// Input stream s_axis: one word per command; tuser gives the kind (order, 1 ms tick,
// set stored state), tdata the valve, the ordered target and the state code.
// Orders and sets act at once; relay sequences start and advance only on tick words.
// Output stream m_axis: exactly one status word per input word, in order: relay drive,
// both valve positions, busy and pending bits, and an error flag for bad set codes.
// Config port: i_cfg_we writes register i_cfg_idx (pulse length, four relay maps);
// the user must write it only while the stream is idle; the block does not enforce this.
// A word accepted on s_axis passes the input register, then a single-pass update into
// the result register, before it is presented on m_axis; a stalled m_axis holds it in the input register.
// Throughput: one word per cycle while m_axis is not stalled; each word's update is a single pass.
// s_axis_tready stays high while the result register is empty or being taken, so a
// stalled receiver holds one result and one waiting input word, then back-pressure.
// Reset (synchronous, active low): both valves unknown, no orders, no pulses, config at
// defaults (100 ticks, relays 0 to 3), both stream registers empty.
module latching_valve_pulse_sequencer_core #(
    parameter int NUM_RELAYS = 4,
    parameter int TIMER_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] valve, [1] open, [9:2] state_code
    input  logic [15:0]                        s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [3:0] relay_drive, [5:4] valve0_state, [7:6] valve1_state,
    // [9:8] busy_res, [11:10] pending, [12] error
    output logic [15:0]                        m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [lvps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lvps_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int RW = $clog2(NUM_RELAYS);
    localparam int NV = lvps_pkg::NUM_VALVES;

    // configuration
    logic [15:0] r_pulse_ticks;
    logic [7:0]  r_map [2*NV];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= 16'd100;
            r_map[0]      <= 8'd0;
            r_map[1]      <= 8'd1;
            r_map[2]      <= 8'd2;
            r_map[3]      <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lvps_pkg::REG_PULSE_TICKS:   r_pulse_ticks <= i_cfg_wdata;
                lvps_pkg::REG_MAP_V0_CLOSED: r_map[0] <= i_cfg_wdata[7:0];
                lvps_pkg::REG_MAP_V0_OPEN:   r_map[1] <= i_cfg_wdata[7:0];
                lvps_pkg::REG_MAP_V1_CLOSED: r_map[2] <= i_cfg_wdata[7:0];
                lvps_pkg::REG_MAP_V1_OPEN:   r_map[3] <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_mode;
    logic       r_in_valve;
    logic       r_in_open;
    logic [7:0] r_in_code;
    logic       w_adv, w_fire, w_accept;

    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_mode  <= s_axis_tuser;
            r_in_valve <= s_axis_tdata[0];
            r_in_open  <= s_axis_tdata[1];
            r_in_code  <= s_axis_tdata[9:2];
        end
    end

    // per-valve sequencers
    lvps_pkg::t_valve_status w_stat  [NV];
    logic [RW-1:0]           w_relay [NV];
    logic [TIMER_BITS-1:0]   w_pulse_load;

    assign w_pulse_load = TIMER_BITS'(r_pulse_ticks);

    for (genvar gv = 0; gv < NV; gv++) begin : g_valve
        lvps_pkg::t_valve_cmd w_cmd;
        assign w_cmd.fire = w_fire;
        assign w_cmd.mode = r_in_mode;
        assign w_cmd.sel  = (r_in_valve == 1'(gv));
        assign w_cmd.open = r_in_open;
        assign w_cmd.code = r_in_code;

        lvps_valve #(
            .NUM_RELAYS (NUM_RELAYS),
            .TIMER_BITS (TIMER_BITS)
        ) u_valve (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_map_closed (r_map[2*gv]),
            .i_map_open   (r_map[2*gv+1]),
            .i_pulse_load (w_pulse_load),
            .o_status     (w_stat[gv]),
            .o_relay      (w_relay[gv])
        );
    end

    // result assembly
    logic [lvps_pkg::DRIVE_W-1:0] w_drive;
    logic                         w_err;

    always_comb begin
        w_drive = '0;
        for (int v = 0; v < NV; v++) begin
            // relays beyond the bank width shift out and are not shown
            if (w_stat[v].busy) begin
                w_drive = w_drive | (lvps_pkg::DRIVE_W'(1) << w_relay[v]);
            end
        end
    end

    assign w_err = (r_in_mode == lvps_pkg::MODE_SET)
                && (r_in_code != lvps_pkg::CODE_CLOSED)
                && (r_in_code != lvps_pkg::CODE_OPEN)
                && (r_in_code != lvps_pkg::CODE_UNKNOWN);

    // result register
    logic        r_out_valid;
    logic [15:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {3'b000, w_err,
                           w_stat[1].pending, w_stat[0].pending,
                           w_stat[1].busy, w_stat[0].busy,
                           w_stat[1].pos, w_stat[0].pos, w_drive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### src/lvps_checker.sv
// Port-level checks for the valve pulse sequencer, bound to the top level.
`include "latching_valve_pulse_sequencer_core_assert.svh"

module lvps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    logic w_stall, w_idle_word, w_any_drive, w_bad_pos;

    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_idle_word = m_axis_tvalid && (m_axis_tdata[9:8] == 2'b00);
    assign w_any_drive = |m_axis_tdata[3:0];
    assign w_bad_pos   = (m_axis_tdata[5:4] == 2'd3) || (m_axis_tdata[7:6] == 2'd3);

    // a stalled result word holds
    `LVPS_ASSERT_RST(a_out_hold, w_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "word not held")

    // reset empties the result register
    `LVPS_ASSERT_ALL(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

    // with the output empty the input side never back-pressures
    `LVPS_ASSERT_RST(a_ready_free, !m_axis_tvalid |-> s_axis_tready, "input stalled, output empty")

    // no relay is driven unless some valve is busy
    `LVPS_ASSERT_RST(a_drive_busy, w_idle_word |-> !w_any_drive, "relay driven while idle")

    // position code 3 never occurs
    `LVPS_ASSERT_RST(a_pos_code, m_axis_tvalid |-> !w_bad_pos, "invalid valve position code")

endmodule

bind latching_valve_pulse_sequencer_core lvps_checker u_lvps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb.sv
// Self-checking testbench for the latching valve pulse sequencer core.
module tb;

    localparam logic [1:0] MODE_IGNORED = 2'd3;  // no effect, status only
    localparam int RELAY_COUNT = 4;
    localparam int SETTINGS_RUN = 8;
    localparam int WORDS_PER_SETTING = 120;

    typedef struct packed {
        logic       err;
        logic [1:0] pend;
        logic [1:0] busy;
        logic [1:0] pos1;
        logic [1:0] pos0;
        logic [3:0] drive;
    } t_status;

    typedef struct {
        logic [1:0] mode;
        logic       valve;
        logic       open;
        logic [7:0] code;
        bit         typed;
        t_status    want;
    } t_dir_row;

    typedef enum {RX_FREE, RX_COIN, RX_EVERY3, RX_LONG} t_rx_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [0] valve, [1] open, [9:2] state_code
    logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] relay_drive, [5:4] valve0_state, [7:6] valve1_state,
    // [9:8] busy_res, [11:10] pending, [12] error
    logic [15:0] m_axis_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [lvps_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lvps_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    latching_valve_pulse_sequencer_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0] cfg_pulse;
    logic [7:0]  cfg_map [4];
    logic [1:0]  vpos [2];
    logic        ord_wait [2];
    logic        ord_tgt [2];
    logic [1:0]  seq_phase [2];
    logic        seq_tgt [2];
    logic [1:0]  seq_relay [2];
    logic [15:0] seq_timer [2];

    t_status     due_status [$];
    t_dir_row    dir_rows [$];
    int          burst_left = 0;
    int          mismatches = 0;
    int          words_sent = 0, ticks_sent = 0, orders_sent = 0, sets_sent = 0;
    int          words_checked = 0;

    function automatic void begin_pulse(int v, logic p, logic [1:0] ph);
        logic [7:0] r;
        r = cfg_map[v*2 + p];
        if (r >= RELAY_COUNT) begin
            vpos[v] = lvps_pkg::POS_UNKNOWN;
            seq_phase[v] = lvps_pkg::PH_IDLE;
            return;
        end
        seq_relay[v] = r[1:0];
        seq_timer[v] = cfg_pulse;
        seq_phase[v] = ph;
    endfunction

    function automatic void advance_valve(int v);
        if (seq_phase[v] == lvps_pkg::PH_IDLE)
            return;
        if (seq_timer[v] > 16'd1) begin
            seq_timer[v]--;
            return;
        end
        seq_timer[v] = '0;
        if (seq_phase[v] == lvps_pkg::PH_PRE) begin
            begin_pulse(v, seq_tgt[v], lvps_pkg::PH_MAIN);
        end else begin
            vpos[v] = {1'b0, seq_tgt[v]};
            seq_phase[v] = lvps_pkg::PH_IDLE;
        end
    endfunction

    function automatic void start_order(int v);
        if (seq_phase[v] != lvps_pkg::PH_IDLE || !ord_wait[v])
            return;
        ord_wait[v] = 1'b0;
        seq_tgt[v] = ord_tgt[v];
        if (vpos[v] == {1'b0, ord_tgt[v]})
            return;
        // unknown position: kick towards the opposite side first
        if (vpos[v] == lvps_pkg::POS_UNKNOWN)
            begin_pulse(v, !ord_tgt[v], lvps_pkg::PH_PRE);
        else
            begin_pulse(v, ord_tgt[v], lvps_pkg::PH_MAIN);
    endfunction

    function automatic t_status status_after(logic [1:0] mode, logic v, logic tgt,
                                             logic [7:0] code);
        t_status st;
        st = '0;
        case (mode)
            lvps_pkg::MODE_ORDER: begin
                ord_wait[v] = 1'b1;
                ord_tgt[v] = tgt;
            end
            lvps_pkg::MODE_TICK: begin
                advance_valve(0);
                advance_valve(1);
                start_order(0);
                start_order(1);
            end
            lvps_pkg::MODE_SET: begin
                case (code)
                    lvps_pkg::CODE_CLOSED:  vpos[v] = lvps_pkg::POS_CLOSED;
                    lvps_pkg::CODE_OPEN:    vpos[v] = lvps_pkg::POS_OPEN;
                    lvps_pkg::CODE_UNKNOWN: vpos[v] = lvps_pkg::POS_UNKNOWN;
                    default:                st.err = 1'b1;
                endcase
            end
            default: ;
        endcase
        for (int i = 0; i < lvps_pkg::NUM_VALVES; i++) begin
            if (seq_phase[i] != lvps_pkg::PH_IDLE) begin
                st.busy[i] = 1'b1;
                st.drive[seq_relay[i]] = 1'b1;
            end
            st.pend[i] = ord_wait[i];
        end
        st.pos0 = vpos[0];
        st.pos1 = vpos[1];
        return st;
    endfunction

    function automatic logic [7:0] rand_relay();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(4, 255))
                                           : 8'($urandom_range(0, 3));
    endfunction

    task automatic add_row(logic [1:0] mode, logic valve, logic open, logic [7:0] code,
                           bit typed, t_status want);
        t_dir_row row;
        row.mode = mode;
        row.valve = valve;
        row.open = open;
        row.code = code;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // entered and left at a falling edge; tvalid stays high between words of a burst
    task automatic send_word(logic [1:0] mode, logic valve, logic open, logic [7:0] code,
                             bit typed, t_status want);
        int gap;
        t_status st;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, code, open, valve};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        st = status_after(mode, valve, open, code);
        due_status.push_back(typed ? want : st);
        words_sent++;
        if (mode == lvps_pkg::MODE_TICK)  ticks_sent++;
        if (mode == lvps_pkg::MODE_ORDER) orders_sent++;
        if (mode == lvps_pkg::MODE_SET)   sets_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (due_status.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] pulse, logic [7:0] m0, logic [7:0] m1,
                                logic [7:0] m2, logic [7:0] m3);
        logic [15:0] vals [5];
        logic [lvps_pkg::CFG_IDX_W-1:0] idx [5];
        vals = '{pulse, {8'h0, m0}, {8'h0, m1}, {8'h0, m2}, {8'h0, m3}};
        idx  = '{lvps_pkg::REG_PULSE_TICKS, lvps_pkg::REG_MAP_V0_CLOSED,
                 lvps_pkg::REG_MAP_V0_OPEN, lvps_pkg::REG_MAP_V1_CLOSED,
                 lvps_pkg::REG_MAP_V1_OPEN};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[k];
            i_cfg_wdata <= vals[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_pulse = pulse;
        cfg_map = '{m0, m1, m2, m3};
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_status want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[12:0];
            if (due_status.size() == 0) begin
                $error("status word with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = due_status.pop_front();
                check_field("relay_drive", 32'(want.drive), 32'(got.drive));
                check_field("valve0_state", 32'(want.pos0), 32'(got.pos0));
                check_field("valve1_state", 32'(want.pos1), 32'(got.pos1));
                check_field("busy_res", 32'(want.busy), 32'(got.busy));
                check_field("pending", 32'(want.pend), 32'(got.pend));
                check_field("error", 32'(want.err), 32'(got.err));
                words_checked++;
            end
        end
    end

    // receiver back-pressure, independent of the sender
    t_rx_style rx_style = RX_FREE;
    int rx_seg_left = 0, rx_hold = 0, rx_count = 0;
    always @(negedge i_clk) begin
        logic rdy;
        if (rx_seg_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_seg_left = $urandom_range(20, 200);
        end
        rx_seg_left--;
        rx_count++;
        case (rx_style)
            RX_FREE:   rdy = 1'b1;
            RX_COIN:   rdy = 1'($urandom_range(0, 1));
            RX_EVERY3: rdy = (rx_count % 3 == 0);
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    rdy = 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_hold = $urandom_range(1, 20);
                    rdy = 1'b0;
                end else begin
                    rdy = 1'b1;
                end
            end
        endcase
        m_axis_tready <= rdy;
    end

    initial begin
        logic [1:0] mode;
        logic [7:0] code;
        int r;
        cfg_pulse = 16'd100;
        cfg_map = '{8'd0, 8'd1, 8'd2, 8'd3};
        for (int v = 0; v < lvps_pkg::NUM_VALVES; v++) begin
            vpos[v] = lvps_pkg::POS_UNKNOWN;
            ord_wait[v] = 1'b0;
            ord_tgt[v] = 1'b0;
            seq_phase[v] = lvps_pkg::PH_IDLE;
            seq_tgt[v] = 1'b0;
            seq_relay[v] = '0;
            seq_timer[v] = '0;
        end

        // fields of typed rows: err, pending, busy, valve1, valve0, relays
        add_row(lvps_pkg::MODE_TICK, 1'b0, 1'b0, 8'h00, 1'b1,
                {1'b0, 2'b00, 2'b00, lvps_pkg::POS_UNKNOWN, lvps_pkg::POS_UNKNOWN, 4'h0});
        add_row(lvps_pkg::MODE_SET, 1'b0, 1'b0, lvps_pkg::CODE_CLOSED, 1'b1,
                {1'b0, 2'b00, 2'b00, lvps_pkg::POS_UNKNOWN, lvps_pkg::POS_CLOSED, 4'h0});
        add_row(lvps_pkg::MODE_SET, 1'b1, 1'b1, lvps_pkg::CODE_OPEN, 1'b1,
                {1'b0, 2'b00, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_CLOSED, 4'h0});
        add_row(lvps_pkg::MODE_SET, 1'b1, 1'b0, 8'h02, 1'b1,
                {1'b1, 2'b00, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_CLOSED, 4'h0});
        add_row(lvps_pkg::MODE_SET, 1'b0, 1'b1, 8'hFE, 1'b1,
                {1'b1, 2'b00, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_CLOSED, 4'h0});
        add_row(lvps_pkg::MODE_SET, 1'b0, 1'b0, lvps_pkg::CODE_UNKNOWN, 1'b1,
                {1'b0, 2'b00, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_UNKNOWN, 4'h0});
        add_row(MODE_IGNORED, 1'b1, 1'b1, 8'hAA, 1'b1,
                {1'b0, 2'b00, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_UNKNOWN, 4'h0});
        add_row(lvps_pkg::MODE_ORDER, 1'b0, 1'b1, 8'h55, 1'b1,
                {1'b0, 2'b01, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_UNKNOWN, 4'h0});
        add_row(lvps_pkg::MODE_ORDER, 1'b0, 1'b0, 8'h00, 1'b1,
                {1'b0, 2'b01, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_UNKNOWN, 4'h0});
        add_row(lvps_pkg::MODE_ORDER, 1'b1, 1'b1, 8'hFF, 1'b1,
                {1'b0, 2'b11, 2'b00, lvps_pkg::POS_OPEN, lvps_pkg::POS_UNKNOWN, 4'h0});
        // v0 pre pulse, v1 already there
        add_row(lvps_pkg::MODE_TICK, 1'b1, 1'b1, 8'hFF, 1'b0, '0);
        add_row(lvps_pkg::MODE_ORDER, 1'b1, 1'b0, 8'h00, 1'b0, '0);
        // v1 straight to target pulse
        add_row(lvps_pkg::MODE_TICK, 1'b0, 1'b0, 8'h00, 1'b0, '0);
        // overwrite while sequence runs
        add_row(lvps_pkg::MODE_SET, 1'b0, 1'b0, lvps_pkg::CODE_OPEN, 1'b0, '0);
        add_row(lvps_pkg::MODE_SET, 1'b1, 1'b1, 8'h80, 1'b0, '0);
        // queued behind the running one
        add_row(lvps_pkg::MODE_ORDER, 1'b0, 1'b1, 8'h00, 1'b0, '0);
        add_row(lvps_pkg::MODE_TICK, 1'b0, 1'b1, 8'h3C, 1'b0, '0);
        add_row(MODE_IGNORED, 1'b0, 1'b0, 8'h00, 1'b0, '0);
        add_row(lvps_pkg::MODE_ORDER, 1'b1, 1'b1, 8'hC3, 1'b0, '0);
        add_row(lvps_pkg::MODE_TICK, 1'b1, 1'b0, 8'hFF, 1'b0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_word(dir_rows[k].mode, dir_rows[k].valve, dir_rows[k].open,
                      dir_rows[k].code, dir_rows[k].typed, dir_rows[k].want);

        for (int p = 0; p < SETTINGS_RUN; p++) begin
            if (p > 0) begin
                drain();
                case (p)
                    1: program_regs(16'd0, 8'd0, 8'd1, 8'd2, 8'd3);       // zero length
                    2: program_regs(16'd3, 8'd3, 8'd2, 8'd1, 8'd0);
                    3: program_regs(16'd2, 8'd4, 8'd1, 8'd255, 8'd2);     // relays out of range
                    4: program_regs(16'hFFFF, 8'd0, 8'd0, 8'd3, 8'd3);
                    5: program_regs(16'd1, 8'd1, 8'd2, 8'd3, 8'd0);
                    default: program_regs(($urandom_range(0, 9) == 0) ?
                                          16'($urandom_range(0, 65535)) :
                                          16'($urandom_range(1, 6)),
                                          rand_relay(), rand_relay(),
                                          rand_relay(), rand_relay());
                endcase
            end
            repeat (WORDS_PER_SETTING) begin
                r = $urandom_range(0, 99);
                mode = (r < 50) ? lvps_pkg::MODE_TICK : (r < 75) ? lvps_pkg::MODE_ORDER :
                       (r < 94) ? lvps_pkg::MODE_SET : MODE_IGNORED;
                code = 8'($urandom_range(0, 255));
                if (mode == lvps_pkg::MODE_SET) begin
                    case ($urandom_range(0, 3))
                        0: code = lvps_pkg::CODE_CLOSED;
                        1: code = lvps_pkg::CODE_OPEN;
                        2: code = lvps_pkg::CODE_UNKNOWN;
                        default: ;
                    endcase
                end
                send_word(mode, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), code,
                          1'b0, '0);
            end
        end
        drain();

        $display("Sent %0d words (%0d ticks, %0d orders, %0d state sets) over %0d settings",
                 words_sent, ticks_sent, orders_sent, sets_sent, SETTINGS_RUN);
        $display("Compared %0d status words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out with %0d status words outstanding", due_status.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/lvps_pkg.sv
src/lvps_valve.sv
src/latching_valve_pulse_sequencer_core.sv
src/lvps_checker.sv
sim/tb.sv
